/* rtl/core/lzwcd_pkg.sv */
// Shared types, constants and helper functions of the LZW code decompressor.
`timescale 1ns / 1ps

package lzwcd_pkg;

   localparam int CODE_W  = 12;
   localparam int IDX_W   = 9;
   localparam int FREE_W  = 10;
   localparam int TOTAL_W = 32;

   localparam logic [CODE_W-1:0] CODE_WIDTH_STEP = 12'd3;
   localparam logic [FREE_W-1:0] ROOT_COUNT      = 10'd260;
   localparam logic [7:0]        END_MARKER      = 8'hFF;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_CORRUPT = 2'd1;
   localparam logic [1:0] ST_HALTED  = 2'd2;

   localparam logic [1:0] KIND_HALT    = 2'd0;
   localparam logic [1:0] KIND_CORRUPT = 2'd1;
   localparam logic [1:0] KIND_END     = 2'd2;

   typedef struct packed {
      logic [7:0]       value;
      logic [IDX_W-1:0] prefix;
   } dict_entry_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      dict_entry_type   entry;
   } dict_wr_type;

   function automatic logic [7:0] root_byte(input logic [IDX_W-1:0] idx);
      logic [IDX_W-1:0] diff;
      begin
         diff = idx - 9'd4;
         root_byte = (idx < 9'd4) ? 8'hFF : diff[7:0];
      end
   endfunction

   function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] total,
                                                  input logic [3:0] n);
      logic [TOTAL_W:0] sum;
      begin
         sum = {1'b0, total} + {29'd0, n};
         sat_add = sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];
      end
   endfunction

endpackage

/* rtl/core/lzw_code_decompressor_unit.sv */
// Top level of the LZW code decompressor: control sequencer, packing and result register.
//
//   channel | direction | tdata                              | tlast      | tuser
//   req     | in        | code_word                          | end_flag   | -
//   rsp     | out       | data_bytes, byte_count, total_bytes| run_last   | stream_end, status
//
// One code at a time: the code is accepted, each prefix link is walked onto the stack until
// the root is reached, then the stacked bytes are popped and packed into result beats.
// Width steps produce no beat; end, halted beats and codes rejected on arrival, as well as
// a chain found corrupt while walking it, give a single beat.
// Reset is synchronous; no clearing pass is needed, entries at or above the free
// pointer read as zero. A stalled result beat holds the packing sequence in place.
`timescale 1ns / 1ps

module lzw_code_decompressor_unit import lzwcd_pkg::*; #(
   parameter int DICT_ENTRIES = 512,
   parameter int STACK_DEPTH  = 256
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [15:0]  req_tdata,   // code_word [11:0], zero fill
   input  logic         req_tlast,   // end_flag
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [103:0] rsp_tdata,   // data_bytes [63:0], byte_count [67:64], total_bytes [99:68]
   output logic         rsp_tlast,   // run_last
   output logic [2:0]   rsp_tuser    // stream_end [0], status [2:1]
);

   localparam int STACK_CAP = (STACK_DEPTH < 255) ? STACK_DEPTH : 255;
   localparam int DW        = $clog2(STACK_CAP + 1);
   localparam int SAW       = $clog2(STACK_DEPTH);

   localparam logic [FREE_W-1:0] DICT_LIMIT = FREE_W'(DICT_ENTRIES);
   localparam logic [DW-1:0]     CAP_V      = DW'(STACK_CAP);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_WALK   = 2'd1;
   localparam logic [1:0] S_POP    = 2'd2;
   localparam logic [1:0] S_SINGLE = 2'd3;

   logic [1:0]         state_ff, state_in;
   logic               halted_ff, halted_in;
   logic [FREE_W-1:0]  nf_ff, nf_in;
   logic [IDX_W-1:0]   prev_ff, prev_in;
   logic [7:0]         fbp_ff, fbp_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [IDX_W-1:0]   code_ff, code_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [DW-1:0]      depth_ff, depth_in;
   logic [7:0]         root_ff, root_in;
   logic [1:0]         kind_ff, kind_in;
   logic [63:0]        asm_ff, asm_in;
   logic [3:0]         cnt_ff, cnt_in;
   logic               pend_ff, pend_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [63:0]        rsp_data_ff, rsp_data_in;
   logic [3:0]         rsp_count_ff, rsp_count_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               rsp_end_ff, rsp_end_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;
   logic [TOTAL_W-1:0] rsp_total_ff, rsp_total_in;

   dict_wr_type        dict_wr;
   logic [IDX_W-1:0]   dict_rd_addr;
   dict_entry_type     dict_rd;

   logic               stk_wr_en;
   logic [SAW-1:0]     stk_wr_addr;
   logic [7:0]         stk_wr_data;
   logic [SAW-1:0]     stk_rd_addr;
   logic [7:0]         stk_rd_data;

   logic               accept;
   logic               out_free;
   logic [CODE_W-1:0]  code;
   logic [CODE_W-1:0]  nf_wide;
   logic               is_entry;
   logic               flush;
   logic               last_beat;
   logic [3:0]         cnt_after;
   logic [DW-1:0]      depth_dec;
   logic [5:0]         shift_amt;

   lzwcd_dict_ram #(
      .DEPTH (DICT_ENTRIES)
   ) u_dict (
      .clock    (clock),
      .wr       (dict_wr),
      .rd_addr  (dict_rd_addr),
      .rd_entry (dict_rd)
   );

   lzwcd_stack_ram #(
      .DEPTH (STACK_DEPTH),
      .AW    (SAW)
   ) u_stack (
      .clock   (clock),
      .wr_en   (stk_wr_en),
      .wr_addr (stk_wr_addr),
      .wr_data (stk_wr_data),
      .rd_addr (stk_rd_addr),
      .rd_data (stk_rd_data)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign code       = req_tdata[CODE_W-1:0];
   assign nf_wide    = {2'b00, nf_ff};
   assign is_entry   = ({1'b0, idx_ff} >= ROOT_COUNT) && ({1'b0, idx_ff} < nf_ff);
   assign flush      = out_free && !pend_ff && ((cnt_ff == 4'd8) || (depth_ff == '0));
   assign last_beat  = (depth_ff == '0);
   assign cnt_after  = flush ? 4'd0 : (cnt_ff + {3'd0, pend_ff});
   assign depth_dec  = depth_ff - 1'b1;
   assign shift_amt  = {cnt_ff[2:0], 3'b000};
   assign stk_rd_addr = depth_dec[SAW-1:0];

   always_comb begin
      state_in      = state_ff;
      halted_in     = halted_ff;
      nf_in         = nf_ff;
      prev_in       = prev_ff;
      fbp_in        = fbp_ff;
      total_in      = total_ff;
      code_in       = code_ff;
      idx_in        = idx_ff;
      depth_in      = depth_ff;
      root_in       = root_ff;
      kind_in       = kind_ff;
      asm_in        = asm_ff;
      cnt_in        = cnt_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_end_in    = rsp_end_ff;
      rsp_status_in = rsp_status_ff;
      rsp_total_in  = rsp_total_ff;
      dict_wr       = '0;
      dict_rd_addr  = dict_rd.prefix;
      stk_wr_en     = 1'b0;
      stk_wr_addr   = depth_ff[SAW-1:0];
      stk_wr_data   = dict_rd.value;

      unique case (state_ff)
         S_IDLE: begin
            dict_rd_addr = (code < nf_wide) ? code[IDX_W-1:0] : prev_ff;
            if (accept) begin
               code_in = code[IDX_W-1:0];
               priority if (halted_ff) begin
                  kind_in  = KIND_HALT;
                  state_in = S_SINGLE;
               end else if (req_tlast) begin
                  kind_in  = KIND_END;
                  state_in = S_SINGLE;
               end else if (code == CODE_WIDTH_STEP) begin
                  state_in = S_IDLE;
               end else if (code < nf_wide) begin
                  idx_in   = code[IDX_W-1:0];
                  depth_in = '0;
                  state_in = S_WALK;
               end else if ((code == nf_wide) && (nf_ff < DICT_LIMIT)) begin
                  // The string is not yet in the dictionary: previous string plus its first byte.
                  stk_wr_en   = 1'b1;
                  stk_wr_addr = '0;
                  stk_wr_data = fbp_ff;
                  idx_in      = prev_ff;
                  depth_in    = DW'(1);
                  state_in    = S_WALK;
               end else begin
                  kind_in  = KIND_CORRUPT;
                  state_in = S_SINGLE;
               end
            end
         end
         S_WALK: begin
            priority if (!is_entry) begin
               root_in  = ({1'b0, idx_ff} < ROOT_COUNT) ? root_byte(idx_ff) : 8'h00;
               asm_in   = {56'd0, root_in};
               cnt_in   = 4'd1;
               pend_in  = 1'b0;
               state_in = S_POP;
            end else if (depth_ff == CAP_V) begin
               kind_in  = KIND_CORRUPT;
               state_in = S_SINGLE;
            end else begin
               stk_wr_en = 1'b1;
               depth_in  = depth_ff + 1'b1;
               idx_in    = dict_rd.prefix;
               if ({1'b0, dict_rd.prefix} >= nf_ff) begin
                  kind_in  = KIND_CORRUPT;
                  state_in = S_SINGLE;
               end
            end
         end
         S_POP: begin
            if (pend_ff) begin
               asm_in = asm_ff | ({56'd0, stk_rd_data} << shift_amt);
               cnt_in = cnt_ff + 4'd1;
            end
            if (flush) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = asm_ff;
               rsp_count_in  = cnt_ff;
               rsp_last_in   = last_beat;
               rsp_end_in    = 1'b0;
               rsp_status_in = ST_OK;
               rsp_total_in  = sat_add(total_ff, cnt_ff);
               total_in      = rsp_total_in;
               asm_in        = '0;
               cnt_in        = 4'd0;
            end
            pend_in = (depth_ff != '0) && !cnt_after[3];
            if (pend_in) begin
               depth_in = depth_dec;
            end
            if (flush && last_beat) begin
               if ((prev_ff != '0) && (nf_ff < DICT_LIMIT)) begin
                  dict_wr.en           = 1'b1;
                  dict_wr.addr         = nf_ff[IDX_W-1:0];
                  dict_wr.entry.value  = root_ff;
                  dict_wr.entry.prefix = prev_ff;
                  nf_in                = nf_ff + 1'b1;
               end
               fbp_in   = root_ff;
               prev_in  = code_ff;
               state_in = S_IDLE;
            end
         end
         S_SINGLE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b1;
               rsp_data_in  = '0;
               rsp_count_in = 4'd0;
               rsp_end_in   = 1'b0;
               rsp_total_in = total_ff;
               state_in     = S_IDLE;
               unique case (kind_ff)
                  KIND_HALT: begin
                     rsp_status_in = ST_HALTED;
                  end
                  KIND_CORRUPT: begin
                     rsp_status_in = ST_CORRUPT;
                     halted_in     = 1'b1;
                  end
                  KIND_END: begin
                     rsp_data_in   = {56'd0, END_MARKER};
                     rsp_count_in  = 4'd1;
                     rsp_end_in    = 1'b1;
                     rsp_status_in = ST_OK;
                     rsp_total_in  = sat_add(total_ff, 4'd1);
                     nf_in         = ROOT_COUNT;
                     prev_in       = '0;
                     fbp_in        = '0;
                     total_in      = '0;
                     halted_in     = 1'b0;
                  end
                  default: begin
                     rsp_status_in = ST_HALTED;
                  end
               endcase
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         halted_ff    <= 1'b0;
         nf_ff        <= ROOT_COUNT;
         prev_ff      <= '0;
         fbp_ff       <= '0;
         total_ff     <= '0;
         depth_ff     <= '0;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         kind_ff      <= KIND_HALT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         halted_ff    <= halted_in;
         nf_ff        <= nf_in;
         prev_ff      <= prev_in;
         fbp_ff       <= fbp_in;
         total_ff     <= total_in;
         depth_ff     <= depth_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         kind_ff      <= kind_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff       <= code_in;
      idx_ff        <= idx_in;
      root_ff       <= root_in;
      asm_ff        <= asm_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_end_ff    <= rsp_end_in;
      rsp_status_ff <= rsp_status_in;
      rsp_total_ff  <= rsp_total_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_total_ff, rsp_count_ff, rsp_data_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = {rsp_status_ff, rsp_end_ff};

`ifndef SYNTHESIS
   a_walk_not_halted: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK) |-> !halted_ff)
      else $error("Prefix walk running while the block is halted.");

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= CAP_V)
      else $error("Stack depth beyond its capacity.");

   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      (nf_ff >= ROOT_COUNT) && (nf_ff <= DICT_LIMIT))
      else $error("Free pointer outside the dictionary.");

   a_append_only_at_end: assert property (@(posedge clock) disable iff (reset)
      dict_wr.en |-> ((state_ff == S_POP) && (dict_wr.entry.prefix != '0)
                      && (state_in == S_IDLE)))
      else $error("Dictionary written outside the end of a string.");

   a_pack_room: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_POP) && pend_ff) |-> (cnt_ff < 4'd8))
      else $error("Stack byte arrives with the packing word full.");
`endif

endmodule

/* rtl/core/lzwcd_dict_ram.sv */
// Dictionary memory holding the byte and prefix of each appended entry.
`timescale 1ns / 1ps

module lzwcd_dict_ram import lzwcd_pkg::*; #(
   parameter int DEPTH = 512
) (
   input  logic              clock,
   input  dict_wr_type       wr,
   input  logic [IDX_W-1:0]  rd_addr,
   output dict_entry_type    rd_entry
);

   localparam int AW = $clog2(DEPTH);

   dict_entry_type mem [DEPTH];
   dict_entry_type rd_entry_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr[AW-1:0]] <= wr.entry;
      end
      rd_entry_ff <= mem[rd_addr[AW-1:0]];
   end

   assign rd_entry = rd_entry_ff;

endmodule

/* rtl/core/lzwcd_stack_ram.sv */
// Reversal stack memory for the bytes met while walking a prefix chain.
`timescale 1ns / 1ps

module lzwcd_stack_ram #(
   parameter int DEPTH = 256,
   parameter int AW    = 8
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* bench/testbench.sv */
// Self-checking testbench for the LZW code decompressor with its own decoding model.
`timescale 1ns / 1ps

module testbench;
   import lzwcd_pkg::*;

   localparam int TABLE_DEPTH = 512;
   localparam int STACK_LIMIT = 255;

   typedef struct packed {
      logic [63:0] data;
      logic [3:0]  count;
      logic        last;
      logic        stream_end;
      logic [1:0]  status;
      logic [31:0] total;
   } decoded_beat_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [15:0]  req_tdata = '0;
   logic         req_tlast = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [103:0] rsp_tdata;
   logic         rsp_tlast;
   logic [2:0]   rsp_tuser;

   // Decoder model state.
   logic [7:0]   dict_byte [0:TABLE_DEPTH-1];
   logic [8:0]   dict_link [0:TABLE_DEPTH-1];
   int unsigned  free_ptr;
   int unsigned  last_code;
   logic [7:0]   last_first;
   logic [31:0]  bytes_out;
   bit           stopped;

   decoded_beat_type due_beats[$];
   decoded_beat_type seen_beat, want_beat;

   int  fault_count = 0;
   int  codes_sent = 0;
   int  streams_sent = 0;
   int  beats_checked = 0;
   bit  tx_gaps = 1'b1;
   bit  rx_gaps = 1'b1;
   int  hold_order = 0;
   int  hold_seen = 0;
   int  hold_len = 0;
   int  hold_left = 0;
   int  gap_left = 0;

   lzw_code_decompressor_unit #(
      .DICT_ENTRIES(TABLE_DEPTH),
      .STACK_DEPTH(256)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .rsp_tuser(rsp_tuser)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic void clear_decoder();
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (i < 4) dict_byte[i] = 8'hFF;
         else if (i < ROOT_COUNT) dict_byte[i] = 8'(i - 4);
         else dict_byte[i] = 8'h00;
         dict_link[i] = '0;
      end
      free_ptr   = 32'(ROOT_COUNT);
      last_code  = 0;
      last_first = 8'h00;
      bytes_out  = '0;
      stopped    = 1'b0;
   endfunction

   function automatic void queue_beat(logic [63:0] data, int unsigned n, logic last,
                                      logic fin, logic [1:0] status);
      decoded_beat_type beat;
      if (bytes_out > 32'hFFFF_FFFF - n) bytes_out = 32'hFFFF_FFFF;
      else bytes_out = bytes_out + n;
      beat.data       = data;
      beat.count      = 4'(n);
      beat.last       = last;
      beat.stream_end = fin;
      beat.status     = status;
      beat.total      = bytes_out;
      due_beats.push_back(beat);
   endfunction

   function automatic void decode_code(logic [CODE_W-1:0] code, logic fin);
      int unsigned idx;
      int unsigned pos;
      int unsigned cnt;
      logic [7:0]  chain[$];
      logic [7:0]  text[$];
      logic [7:0]  head;
      logic [63:0] word;
      bit          bad;
      if (stopped) begin
         queue_beat('0, 0, 1'b1, 1'b0, ST_HALTED);
         return;
      end
      if (fin) begin
         queue_beat(64'(END_MARKER), 1, 1'b1, 1'b1, ST_OK);
         clear_decoder();
         return;
      end
      if (code == CODE_WIDTH_STEP) return;
      bad = 1'b0;
      idx = 0;
      if (code < free_ptr) begin
         idx = 32'(code);
      end else if (code == free_ptr && free_ptr < TABLE_DEPTH) begin
         chain.push_back(last_first);
         idx = last_code;
      end else begin
         bad = 1'b1;
      end
      while (!bad && dict_link[idx] != 0) begin
         if (chain.size() >= STACK_LIMIT) begin
            bad = 1'b1;
            break;
         end
         chain.push_back(dict_byte[idx]);
         idx = 32'(dict_link[idx]);
         if (idx >= free_ptr) begin
            bad = 1'b1;
            break;
         end
      end
      if (bad) begin
         stopped = 1'b1;
         queue_beat('0, 0, 1'b1, 1'b0, ST_CORRUPT);
         return;
      end
      head = dict_byte[idx];
      text.push_back(head);
      while (chain.size() > 0) text.push_back(chain.pop_back());
      for (pos = 0; pos < text.size(); pos += 8) begin
         cnt = (text.size() - pos < 8) ? text.size() - pos : 8;
         word = '0;
         for (int j = 0; j < cnt; j++) word[8*j +: 8] = text[pos + j];
         queue_beat(word, cnt, (pos + cnt >= text.size()), 1'b0, ST_OK);
      end
      if (last_code != 0 && free_ptr < TABLE_DEPTH) begin
         dict_byte[free_ptr] = head;
         dict_link[free_ptr] = 9'(last_code);
         free_ptr++;
      end
      last_first = head;
      last_code  = 32'(code);
   endfunction

   function automatic void log_fault(string msg);
      fault_count++;
      if (fault_count <= 10) $display("%s", msg);
   endfunction

   // Result checker: every accepted beat is compared with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         seen_beat.data       = rsp_tdata[63:0];
         seen_beat.count      = rsp_tdata[67:64];
         seen_beat.total      = rsp_tdata[99:68];
         seen_beat.last       = rsp_tlast;
         seen_beat.stream_end = rsp_tuser[0];
         seen_beat.status     = rsp_tuser[2:1];
         if (due_beats.size() == 0) begin
            log_fault($sformatf("Unexpected result beat at %0t: data %h count %0d status %0d",
                                $realtime, seen_beat.data, seen_beat.count, seen_beat.status));
         end else begin
            want_beat = due_beats.pop_front();
            if (seen_beat.data !== want_beat.data || seen_beat.count !== want_beat.count ||
                seen_beat.last !== want_beat.last ||
                seen_beat.stream_end !== want_beat.stream_end ||
                seen_beat.status !== want_beat.status || seen_beat.total !== want_beat.total)
               log_fault($sformatf({"Beat %0d mismatch at %0t:\n",
                  "  expected data %h count %0d last %b end %b status %0d total %0d\n",
                  "  actual   data %h count %0d last %b end %b status %0d total %0d"},
                  beats_checked, $realtime,
                  want_beat.data, want_beat.count, want_beat.last, want_beat.stream_end,
                  want_beat.status, want_beat.total,
                  seen_beat.data, seen_beat.count, seen_beat.last, seen_beat.stream_end,
                  seen_beat.status, seen_beat.total));
         end
         beats_checked++;
      end
   end

   // Result receiver: random stall bursts, plus long hold-offs on request.
   always @(negedge clock) begin
      if (hold_seen != hold_order) begin
         hold_seen = hold_order;
         hold_left = hold_len;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (gap_left > 0) begin
         gap_left--;
         rsp_tready <= 1'b0;
      end else if (rx_gaps && $urandom_range(0, 7) == 0) begin
         gap_left = $urandom_range(0, 16);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic send_code(input logic [CODE_W-1:0] code, input logic fin);
      if (tx_gaps && $urandom_range(0, 4) == 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end else begin
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'd0, code};
      req_tlast  <= fin;
      do @(posedge clock); while (req_tready !== 1'b1);
      decode_code(code, fin);
      codes_sent++;
   endtask

   task automatic end_stream();
      send_code(CODE_W'($urandom_range(0, 4095)), 1'b1);
      streams_sent++;
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (due_beats.size() != 0) @(posedge clock);
   endtask

   function automatic logic [CODE_W-1:0] pick_code();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 8) return CODE_W'($urandom_range(0, 2));
      if (r < 14) return CODE_WIDTH_STEP;
      if (r < 28 && free_ptr < TABLE_DEPTH && last_code != 0 && last_code < free_ptr)
         return CODE_W'(free_ptr);
      if (r < 65 && free_ptr > ROOT_COUNT)
         return CODE_W'($urandom_range(ROOT_COUNT, free_ptr - 1));
      return CODE_W'($urandom_range(4, free_ptr - 1));
   endfunction

   task automatic test_directed_strings();
      logic [CODE_W-1:0] codes[$];
      codes = '{12'd4, 12'd259, CODE_WIDTH_STEP, 12'd261, 12'd260, 12'd262,
                12'd1, 12'd2, 12'd0, 12'd264, 12'd266, 12'd263, 12'd5};
      foreach (codes[i]) send_code(codes[i], 1'b0);
      end_stream();
      drain_results();
   endtask

   task automatic test_long_strings();
      send_code(CODE_W'($urandom_range(4, 259)), 1'b0);
      repeat (48) send_code(CODE_W'(free_ptr), 1'b0);
      send_code(CODE_WIDTH_STEP, 1'b0);
      send_code(CODE_W'($urandom_range(ROOT_COUNT, free_ptr - 1)), 1'b0);
      end_stream();
      drain_results();
   endtask

   task automatic test_random_streams();
      int stream_len;
      repeat (5) begin
         tx_gaps = ($urandom_range(0, 2) != 0);
         rx_gaps = ($urandom_range(0, 2) != 0);
         stream_len = $urandom_range(5, 30);
         repeat (stream_len) send_code(pick_code(), 1'b0);
         end_stream();
      end
      tx_gaps = 1'b1;
      rx_gaps = 1'b1;
      drain_results();
   endtask

   task automatic test_backpressure();
      send_code(CODE_W'($urandom_range(4, 259)), 1'b0);
      repeat (12) send_code(CODE_W'(free_ptr), 1'b0);
      hold_len = 300;
      hold_order++;
      repeat (20) send_code(pick_code(), 1'b0);
      drain_results();
      repeat (10) send_code(pick_code(), 1'b0);
      end_stream();
      drain_results();
   endtask

   // A first code equal to the free pointer leaves the previous code above the table,
   // so the next entry points to itself and walking it overruns the stack.
   task automatic test_corrupt_halt();
      tx_gaps = 1'b0;
      rx_gaps = 1'b0;
      send_code(CODE_W'(ROOT_COUNT), 1'b0);
      send_code(12'd7, 1'b0);
      send_code(CODE_W'(ROOT_COUNT), 1'b0);
      send_code(12'hFFF, 1'b0);
      send_code(CODE_WIDTH_STEP, 1'b0);
      send_code(12'd4, 1'b0);
      end_stream();
      repeat (4) send_code(CODE_W'($urandom_range(0, 4095)), 1'($urandom_range(0, 1)));
      drain_results();
   endtask

   initial begin
      clear_decoder();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_strings();
      test_long_strings();
      test_random_streams();
      test_backpressure();
      test_corrupt_halt();
      repeat (300) @(posedge clock);
      if (due_beats.size() != 0)
         log_fault($sformatf("%0d expected beats never arrived", due_beats.size()));
      $display("Sent %0d codes in %0d streams: width steps, unseen strings, long chains,",
               codes_sent, streams_sent);
      $display("long hold-offs and a stack overrun with halt; %0d beats checked, %0d faults.",
               beats_checked, fault_count);
      if (fault_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #8_000_000;
      $display("Timeout with %0d beats still expected.", due_beats.size());
      $display("CHECK FAILED");
      $finish;
   end

endmodule

/* lzw_code_decompressor_unit.f */
rtl/core/lzwcd_pkg.sv
rtl/core/lzwcd_dict_ram.sv
rtl/core/lzwcd_stack_ram.sv
rtl/core/lzw_code_decompressor_unit.sv
bench/testbench.sv
